FILE: hdl/stage_message_frame_checker_assert.svh
// Assertion macros used by the frame checker core.
`ifndef STAGE_MESSAGE_FRAME_CHECKER_ASSERT_SVH
`define STAGE_MESSAGE_FRAME_CHECKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SMFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/smfc_pkg.sv
// Shared constants, types and the CRC byte update of the frame checker.
package smfc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;
    localparam int BODY_LEN  = 26;
    localparam int FRAME_LEN = 28;
    localparam int COUNT_MAX = 29;
    localparam int COUNT_W   = 5;
    localparam logic [7:0] VERSION_RESET = 8'd1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CRC     = 2'd1,
        ST_BAD_VERSION = 2'd2
    } t_status;

    // The last member sits in the lowest bits, so flags occupies bits 7:0 of the packed word.
    typedef struct packed {
        logic [31:0] nonce;
        logic [7:0]  second_sync_index;
        logic [7:0]  second_channels;
        logic [31:0] second_stop;
        logic [31:0] second_start;
        logic [7:0]  primary_sync_index;
        logic [7:0]  primary_channels;
        logic [31:0] primary_stop;
        logic [31:0] primary_start;
        logic [7:0]  flags;
    } t_fields;

    typedef struct packed {
        t_status status;
        t_fields fields;
    } t_result;

    typedef struct packed {
        logic       fire;
        logic       last;
        logic [7:0] data;
    } t_beat;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/smfc_in_stage.sv
// Input register that holds one received byte until the checker core takes it.
module smfc_in_stage
    import smfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_out_busy,
    output t_beat      o_beat
);

    logic       r_valid;
    logic       r_last;
    logic [7:0] r_data;
    logic       w_fire;
    logic       w_take;

    // A byte that ends a frame waits while the result register is full and not being taken.
    assign w_fire     = r_valid && !(r_last && i_out_busy);
    assign o_s_tready = !r_valid || w_fire;
    assign w_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (w_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= i_s_tdata;
            r_last <= i_s_tlast;
        end
    end

    assign o_beat.fire = w_fire;
    assign o_beat.last = r_last;
    assign o_beat.data = r_data;

endmodule

FILE: hdl/smfc_core.sv
// Running CRC, byte store, length count and status decision of the frame checker.
`include "stage_message_frame_checker_assert.svh"
module smfc_core
    import smfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  t_beat      i_beat,
    output logic       o_res_valid,
    output t_result    o_result
);

    logic [7:0]         r_version;
    logic [15:0]        r_crc;
    logic [15:0]        n_crc;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [15:0]        r_recv;
    logic [15:0]        n_recv;
    logic [7:0]         r_store [BODY_LEN];
    logic               w_in_body;
    t_status            w_status;
    t_fields            w_fields;

    assign w_in_body = r_count < COUNT_W'(BODY_LEN);

    always_comb begin
        n_crc   = r_crc;
        n_recv  = r_recv;
        n_count = r_count;
        if (w_in_body) begin
            n_crc = crc16_byte(r_crc, i_beat.data);
        end else if (r_count == COUNT_W'(BODY_LEN)) begin
            n_recv = {r_recv[15:8], i_beat.data};
        end else if (r_count == COUNT_W'(BODY_LEN + 1)) begin
            n_recv = {i_beat.data, r_recv[7:0]};
        end
        if (r_count < COUNT_W'(COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_comb begin
        if (n_count != COUNT_W'(FRAME_LEN) || n_crc != n_recv) begin
            w_status = ST_BAD_CRC;
        end else if (r_store[0] != r_version) begin
            w_status = ST_BAD_VERSION;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        w_fields = '0;
        if (w_status == ST_OK) begin
            w_fields.flags              = r_store[1];
            w_fields.primary_start      = {r_store[5], r_store[4], r_store[3], r_store[2]};
            w_fields.primary_stop       = {r_store[9], r_store[8], r_store[7], r_store[6]};
            w_fields.primary_channels   = r_store[10];
            w_fields.primary_sync_index = r_store[11];
            w_fields.second_start       = {r_store[15], r_store[14], r_store[13], r_store[12]};
            w_fields.second_stop        = {r_store[19], r_store[18], r_store[17], r_store[16]};
            w_fields.second_channels    = r_store[20];
            w_fields.second_sync_index  = r_store[21];
            w_fields.nonce              = {r_store[25], r_store[24], r_store[23], r_store[22]};
        end
    end

    assign o_res_valid     = i_beat.fire && i_beat.last;
    assign o_result.status = w_status;
    assign o_result.fields = w_fields;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VERSION_RESET;
        end else if (i_cfg_wr_en) begin
            r_version <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_count <= '0;
            r_recv  <= '0;
        end else if (i_beat.fire) begin
            if (i_beat.last) begin
                r_crc   <= CRC_INIT;
                r_count <= '0;
                r_recv  <= '0;
            end else begin
                r_crc   <= n_crc;
                r_count <= n_count;
                r_recv  <= n_recv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat.fire && w_in_body) begin
            r_store[r_count] <= i_beat.data;
        end
    end

    `SMFC_ASSERT_IMPLY(a_count_saturates, i_clk, i_rst_n, 1'b1, r_count <= COUNT_W'(COUNT_MAX), "byte count ran past its saturation value")
    `SMFC_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, i_beat.fire && i_beat.last, r_count == '0 && r_crc == CRC_INIT && r_recv == '0, "frame state did not restart after the last byte")
    `SMFC_ASSERT_IMPLY(a_ok_length, i_clk, i_rst_n, o_res_valid && w_status == ST_OK, r_count == COUNT_W'(FRAME_LEN - 1), "good status on a frame of the wrong length")

endmodule

FILE: hdl/smfc_out_reg.sv
// Result register that holds one frame result until the downstream side takes it.
module smfc_out_reg
    import smfc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_res_valid,
    input  t_result        i_result,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output logic [199:0]   o_m_tdata,
    output logic [1:0]     o_m_tuser,
    output logic           o_busy
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_result <= i_result;
        end
    end

    assign o_busy     = r_valid && !i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_result.fields;
    assign o_m_tuser  = r_result.status;

endmodule

FILE: hdl/stage_message_frame_checker.sv
// Top level of the staging message frame checker.
// The block takes a received frame one byte per transfer, with tlast on the final byte, and
// gives one result per frame: a status in tuser and the decoded little-endian fields in tdata.
// A frame is good when it is exactly 28 bytes long, the CRC-16/CCITT-FALSE over bytes 0 to 25
// matches the CRC carried low byte first in bytes 26 and 27, and byte 0 equals the configured
// version; the length and CRC check comes before the version check, and every field is zero
// unless the status is good. One byte is accepted per clock cycle, since the whole 8-bit CRC
// update is combinational XOR logic between the input register and the frame state, except
// while a final byte waits on a full result register. The result is valid once the final
// byte has left the input register and its result is loaded into the result register; while a
// result waits, bytes of the next frame keep flowing and only its final byte is held back.
module stage_message_frame_checker
    import smfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [7:0]   i_cfg_wr_data,   // expected_version
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,         // data_byte
    input  logic         s_tlast,         // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // flags, primary_start, primary_stop, primary_channels, primary_sync_index,
    // second_start, second_stop, second_channels, second_sync_index, nonce
    output logic [199:0] m_tdata,
    output logic [1:0]   m_tuser          // status
);

    t_beat   w_beat;
    t_result w_result;
    logic    w_res_valid;
    logic    w_out_busy;

    smfc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_out_busy (w_out_busy),
        .o_beat     (w_beat)
    );

    smfc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_beat        (w_beat),
        .o_res_valid   (w_res_valid),
        .o_result      (w_result)
    );

    smfc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_result    (w_result),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_busy      (w_out_busy)
    );

endmodule
